[rtl/json_string_unescape_decoder_core_assert.svh]
// Assertion macros for the JSON string unescape decoder.
// Used by modules that have clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_DECODER_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("jsu: next-cycle check failed");

`endif

[rtl/jsu_pkg.sv]
// Package for the JSON string unescape decoder: codes, command type, helpers.
// No dependencies.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX
    } phase_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NO_QUOTE = 2'd0;
    localparam logic [1:0] ERR_END      = 2'd1;
    localparam logic [1:0] ERR_ESCAPE   = 2'd2;
    localparam logic [1:0] ERR_HEX      = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] CP_ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [5:0]  UTF8_MASK6 = 6'h3F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // One queued request: up to three result items from one input byte.
    typedef struct packed {
        logic [1:0] last_idx;   // number of results minus one
        logic [1:0] kind;
        logic [1:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } cmd_t;

    // {not_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            r = {1'b0, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
            r = {1'b0, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

    // {known, decoded byte} for single-letter escapes
    function automatic logic [8:0] esc_decode(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage

[rtl/jsu_front.sv]
// Front end: parses input bytes and builds result requests.
// Depends on jsu_pkg and the assertion header.
`include "json_string_unescape_decoder_core_assert.svh"

module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       push,
    output cmd_t       cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [11:0] code_reg, code_next;   // first three hex digits

    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [15:0] cp;
    logic        emit;

    assign hex = hex_decode(in_byte);
    assign esc = esc_decode(in_byte);
    assign cp  = {code_reg, hex[3:0]};
    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= 2'd0;
            code_reg    <= 12'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            code_reg    <= code_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = 2'd0;
        code_next    = 12'd0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!text_end && in_byte == CH_QUOTE)
                    phase_next = PH_STR;
            end
            PH_STR:
            begin
                if (text_end || in_byte == CH_QUOTE)
                    phase_next = PH_IDLE;
                else if (in_byte == CH_BSLASH)
                    phase_next = PH_ESC;
            end
            PH_ESC:
            begin
                if (text_end)
                    phase_next = PH_IDLE;
                else if (in_byte == CH_U)
                    phase_next = PH_HEX;
                else if (esc[8])
                    phase_next = PH_STR;
                else
                    phase_next = PH_IDLE;
            end
            PH_HEX:
            begin
                if (text_end || hex[4])
                    phase_next = PH_IDLE;
                else if (hex_cnt_reg == 2'd3)
                    phase_next = PH_STR;
                else
                begin
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                    code_next    = {code_reg[7:0], hex[3:0]};
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // request contents
    always_comb
    begin
        emit = 1'b0;
        cmd  = '{last_idx: 2'd0, kind: KIND_BYTE, err: 2'd0,
                 b0: 8'd0, b1: 8'd0, b2: 8'd0};
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!text_end && in_byte != CH_QUOTE)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_NO_QUOTE;
                end
            end
            PH_STR:
            begin
                if (text_end)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_END;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_DONE;
                end
                else if (in_byte != CH_BSLASH)
                begin
                    emit   = 1'b1;
                    cmd.b0 = in_byte;
                end
            end
            PH_ESC:
            begin
                if (text_end)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_END;
                end
                else if (esc[8])
                begin
                    emit   = 1'b1;
                    cmd.b0 = esc[7:0];
                end
                else if (in_byte != CH_U)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_ESCAPE;
                end
            end
            PH_HEX:
            begin
                if (text_end)
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_END;
                end
                else if (hex[4])
                begin
                    emit     = 1'b1;
                    cmd.kind = KIND_ERROR;
                    cmd.err  = ERR_HEX;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    emit = 1'b1;
                    if (cp < CP_ONE_BYTE_LIMIT)
                        cmd.b0 = cp[7:0];
                    else if (cp < CP_TWO_BYTE_LIMIT)
                    begin
                        cmd.last_idx = 2'd1;
                        cmd.b0 = UTF8_LEAD2 | {3'd0, cp[10:6]};
                        cmd.b1 = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK6};
                    end
                    else
                    begin
                        cmd.last_idx = 2'd2;
                        cmd.b0 = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        cmd.b1 = UTF8_CONT | {2'd0, cp[11:6] & UTF8_MASK6};
                        cmd.b2 = UTF8_CONT | {2'd0, cp[5:0] & UTF8_MASK6};
                    end
                end
            end
            default: emit = 1'b0;
        endcase
    end

    `JSU_ASSERT_IMP(a_fr_hex_cnt_idle, phase_reg != PH_HEX, hex_cnt_reg == 2'd0)

endmodule

[rtl/jsu_queue.sv]
// Short request queue between the parser front end and the output back end.
// Depends on jsu_pkg and the assertion header.
`include "json_string_unescape_decoder_core_assert.svh"

module jsu_queue
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    `JSU_ASSERT_IMP(a_q_no_overflow, push, !full)
    `JSU_ASSERT_IMP(a_q_no_underflow, pop, !empty)

endmodule

[rtl/jsu_back.sv]
// Back end: expands queued requests into single results in an output register.
// Depends on jsu_pkg and the assertion header.
`include "json_string_unescape_decoder_core_assert.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic [1:0] error_code,
    output logic       last
);

    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg, err_reg;
    logic       last_reg;
    logic [1:0] idx_reg;

    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !out_valid_reg || !out_stall;
    assign is_last = (idx_reg == head.last_idx);
    assign pop     = load && !empty && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            default: sel_byte = head.b2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= !empty;
            if (!empty)
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg <= sel_byte;
            kind_reg <= head.kind;
            err_reg  <= head.err;
            last_reg <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign kind       = kind_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

    `JSU_ASSERT_IMP(a_bk_zero_byte, out_valid_reg && kind_reg != KIND_BYTE, byte_reg == 8'd0)
    `JSU_ASSERT_IMP(a_bk_mid_request, idx_reg != 2'd0, !empty)
    `JSU_ASSERT_NXT(a_bk_hold_mid, idx_reg != 2'd0 && !load, idx_reg == $past(idx_reg))

endmodule

[rtl/json_string_unescape_decoder_core.sv]
// Top level of the JSON string unescape decoder.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Channel | Handshake              | Payload
// --------+------------------------+-----------------------------------------
// input   | in_valid / in_stall    | in_byte, text_end
// output  | out_valid / out_stall  | out_byte, kind, error_code, last
//
// One input byte is taken per cycle while the request queue has room.
// Each byte yields zero to three results; the back end sends one per cycle while
// out_stall is low, so a \uXXXX escape that becomes three UTF-8 bytes gives three results.
// in_stall is high only when the four-entry request queue is full.
// Output results sit in a register; a stalled result holds and the front
// keeps parsing until the queue fills. rst_n clears parser state and queue.

module json_string_unescape_decoder_core
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic [1:0] error_code,
    output logic       last
);

    logic accept;
    logic push, pop;
    logic q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    // Stall on a full queue regardless of whether the byte makes a result.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Parser: phase machine plus hex gathering, builds at most one request per byte.
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .text_end (text_end),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Decouples parsing from output pacing.
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Serializer: one result per cycle out of the head request while out_stall is low.
    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .empty      (q_empty),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

endmodule

[dv/tb_json_string_unescape_decoder_core.sv]
// Testbench for json_string_unescape_decoder_core: directed, backpressure and random string tests.
// Needs jsu_pkg and the decoder RTL. A built-in decoder model predicts every result,
// and a monitor compares the block's results with those predictions in order.
`timescale 1ns / 100ps

module tb_json_string_unescape_decoder_core;
    import jsu_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT   = 200000;  // watchdog, far above the slowest legal run
    localparam int DRAIN_LIMIT   = 20000;   // bound on waiting for outstanding results
    localparam int SETTLE_CYCLES = 16;      // quiet cycles after the last result
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off in the pressure test
    localparam int RANDOM_ITEMS  = 500;

    // Text characters used to build stimulus
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_F = 8'h46;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_N = 8'h6E;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] CH_LC_Q = 8'h71;
    localparam logic [7:0] CH_LC_G = 8'h67;

    // Ways to break a random string
    typedef enum int {
        FAULT_NONE,
        FAULT_END_IN_STR,
        FAULT_END_AFTER_BSLASH,
        FAULT_BAD_ESCAPE,
        FAULT_BAD_HEX,
        FAULT_STRAY_BYTE
    } fault_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } result_t;

    // DUT ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       text_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
    logic       last;

    // Decoder model state
    phase_t      parse_phase = PH_IDLE;
    logic [1:0]  hex_seen = 2'd0;
    logic [15:0] cp_acc = 16'h0000;

    result_t expected_results[$];   // predicted results not yet seen
    result_t step_results[$];       // results caused by the request being predicted
    result_t seen_result;
    result_t want_result;

    int   error_count = 0;
    int   items_sent = 0;
    int   burst_left = 0;
    int   cycle_count = 0;
    logic hold_off = 1'b0;
    logic [11:0] stall_tick = 12'd0;

    json_string_unescape_decoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .text_end   (text_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic void emit_result(input logic [7:0] b, input logic [1:0] k,
                                        input logic [1:0] code);
        result_t r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = code;
        r.last       = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void clear_hex();
        hex_seen = 2'd0;
        cp_acc   = 16'h0000;
    endfunction

    // Any error drops back to waiting for a quote.
    function automatic void raise_error(input logic [1:0] code);
        parse_phase = PH_IDLE;
        clear_hex();
        emit_result(8'h00, KIND_ERROR, code);
    endfunction

    // -1 when c is not a hex digit
    function automatic int hex_value_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    // {known, value} of a one-letter escape
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            CH_SLASH:  return {1'b1, CH_SLASH};
            CH_LC_B:   return {1'b1, 8'h08};
            CH_LC_F:   return {1'b1, 8'h0C};
            CH_LC_N:   return {1'b1, 8'h0A};
            CH_LC_R:   return {1'b1, 8'h0D};
            CH_LC_T:   return {1'b1, 8'h09};
            default:   return {1'b0, 8'h00};
        endcase
    endfunction

    function automatic logic [7:0] escape_letter(input int idx);
        case (idx)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_LC_B;
            4:       return CH_LC_F;
            5:       return CH_LC_N;
            6:       return CH_LC_R;
            default: return CH_LC_T;
        endcase
    endfunction

    // Code point to UTF-8; surrogates are encoded as plain 3-byte sequences.
    function automatic void emit_utf8(input logic [15:0] cp);
        if (cp < CP_ONE_BYTE_LIMIT)
        begin
            emit_result(cp[7:0], KIND_BYTE, 2'd0);
        end
        else if (cp < CP_TWO_BYTE_LIMIT)
        begin
            emit_result(UTF8_LEAD2 | {3'b000, cp[10:6]}, KIND_BYTE, 2'd0);
            emit_result(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK6}, KIND_BYTE, 2'd0);
        end
        else
        begin
            emit_result(UTF8_LEAD3 | {4'b0000, cp[15:12]}, KIND_BYTE, 2'd0);
            emit_result(UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK6}, KIND_BYTE, 2'd0);
            emit_result(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK6}, KIND_BYTE, 2'd0);
        end
    endfunction

    // Advance the model by one accepted request and queue what it should produce.
    task automatic predict_decode(input logic [7:0] b, input logic e);
        int          nib;
        logic [8:0]  esc;
        logic [15:0] cp;
        result_t     tail;
        step_results.delete();
        case (parse_phase)
            PH_IDLE:
            begin
                // end of text while waiting is silent
                if (!e)
                begin
                    if (b == CH_QUOTE)
                    begin
                        parse_phase = PH_STR;
                        clear_hex();
                    end
                    else
                    begin
                        raise_error(ERR_NO_QUOTE);
                    end
                end
            end
            PH_STR:
            begin
                if (e)
                begin
                    raise_error(ERR_END);
                end
                else if (b == CH_QUOTE)
                begin
                    parse_phase = PH_IDLE;
                    clear_hex();
                    emit_result(8'h00, KIND_DONE, 2'd0);
                end
                else if (b == CH_BSLASH)
                begin
                    parse_phase = PH_ESC;
                end
                else
                begin
                    emit_result(b, KIND_BYTE, 2'd0);
                end
            end
            PH_ESC:
            begin
                if (e)
                begin
                    raise_error(ERR_END);
                end
                else if (b == CH_U)
                begin
                    parse_phase = PH_HEX;
                    clear_hex();
                end
                else
                begin
                    esc = escape_value(b);
                    if (esc[8])
                    begin
                        parse_phase = PH_STR;
                        emit_result(esc[7:0], KIND_BYTE, 2'd0);
                    end
                    else
                    begin
                        raise_error(ERR_ESCAPE);
                    end
                end
            end
            default:
            begin
                if (e)
                begin
                    raise_error(ERR_END);
                end
                else
                begin
                    nib = hex_value_of(b);
                    if (nib < 0)
                    begin
                        raise_error(ERR_HEX);
                    end
                    else
                    begin
                        cp_acc = {cp_acc[11:0], nib[3:0]};
                        if (hex_seen == 2'd3)
                        begin
                            cp = cp_acc;
                            parse_phase = PH_STR;
                            clear_hex();
                            emit_utf8(cp);
                        end
                        else
                        begin
                            hex_seen = hex_seen + 2'd1;
                        end
                    end
                end
            end
        endcase
        if (step_results.size() > 0)
        begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        while (step_results.size() > 0)
            expected_results.push_back(step_results.pop_front());
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 200)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_result = '{out_byte, kind, error_code, last};
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte=%h kind=%0d err=%0d last=%0b",
                                          out_byte, kind, error_code, last));
            end
            else
            begin
                want_result = expected_results.pop_front();
                if (seen_result.out_byte !== want_result.out_byte
                    || seen_result.kind !== want_result.kind
                    || seen_result.error_code !== want_result.error_code
                    || seen_result.last !== want_result.last)
                    report_mismatch($sformatf(
                        "got byte=%h kind=%0d err=%0d last=%0b, want byte=%h kind=%0d err=%0d last=%0b",
                        seen_result.out_byte, seen_result.kind, seen_result.error_code,
                        seen_result.last, want_result.out_byte, want_result.kind,
                        want_result.error_code, want_result.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: the stall pattern steps with stall_tick[9:8] through
    //   quiet stretch, light random stalls, heavy random stalls, fixed pattern.
    // hold_off overrides everything for the long backpressure stretch.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 12'd1;
        if (hold_off)
            out_stall <= 1'b1;
        else
        begin
            case (stall_tick[9:8])
                2'd0:    out_stall <= 1'b0;
                2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_tick[2] & stall_tick[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken. Requests go out in bursts;
    // between bursts the channel may idle with junk payload.
    task automatic send_request(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                in_byte  <= 8'($urandom_range(0, 255));
                text_end <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        text_end <= e;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        predict_decode(b, e);
    endtask

    // \uXXXX; upper picks the letter case of each digit
    task automatic send_unicode_escape(input logic [15:0] cp, input logic [3:0] upper);
        int          i;
        logic [3:0]  nib;
        logic [7:0]  c;
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_U, 1'b0);
        for (i = 3; i >= 0; i--)
        begin
            nib = cp[i*4 +: 4];
            if (nib < 4'd10)
                c = CH_ZERO + nib;
            else
                c = (upper[i] ? CH_UC_A : CH_LC_A) + (nib - 4'd10);
            send_request(c, 1'b0);
        end
    endtask

    // Lower valid, wait for all outstanding results, then let the channel settle.
    task automatic wait_drained();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random string: mostly well formed, sometimes broken, now and then
    // preceded by noise while the block waits for a quote.
    task automatic send_random_string();
        int          n_elems;
        int          fault_pos;
        int          i;
        int          digits;
        int          cls;
        fault_t      fault;
        logic [7:0]  c;
        logic [15:0] cp;
        if ($urandom_range(0, 7) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE)
                    c = 8'($urandom_range(0, 255));
                send_request(c, 1'b0);
            end
        end
        n_elems   = $urandom_range(0, 6);
        fault     = ($urandom_range(0, 5) == 0) ? fault_t'($urandom_range(1, 5)) : FAULT_NONE;
        fault_pos = $urandom_range(0, n_elems);
        send_request(CH_QUOTE, 1'b0);
        for (i = 0; i <= n_elems; i++)
        begin
            if (fault != FAULT_NONE && i == fault_pos)
            begin
                case (fault)
                    FAULT_END_IN_STR:
                        send_request(8'($urandom_range(0, 255)), 1'b1);
                    FAULT_END_AFTER_BSLASH:
                    begin
                        send_request(CH_BSLASH, 1'b0);
                        send_request(8'($urandom_range(0, 255)), 1'b1);
                    end
                    FAULT_BAD_ESCAPE:
                    begin
                        c = 8'($urandom_range(0, 255));
                        while (escape_value(c) != 9'd0 || c == CH_U)
                            c = 8'($urandom_range(0, 255));
                        send_request(CH_BSLASH, 1'b0);
                        send_request(c, 1'b0);
                    end
                    FAULT_BAD_HEX:
                    begin
                        send_request(CH_BSLASH, 1'b0);
                        send_request(CH_U, 1'b0);
                        digits = $urandom_range(0, 3);
                        repeat (digits)
                        begin
                            cp[3:0] = 4'($urandom_range(0, 15));
                            c = (cp[3:0] < 4'd10) ? CH_ZERO + cp[3:0]
                                                  : CH_UC_A + (cp[3:0] - 4'd10);
                            send_request(c, 1'b0);
                        end
                        if ($urandom_range(0, 1) == 0)
                            send_request(8'($urandom_range(0, 255)), 1'b1);
                        else
                        begin
                            c = 8'($urandom_range(0, 255));
                            while (hex_value_of(c) >= 0)
                                c = 8'($urandom_range(0, 255));
                            send_request(c, 1'b0);
                        end
                    end
                    default:
                        // any byte at all; may close the string or start an escape
                        send_request(8'($urandom_range(0, 255)), 1'b0);
                endcase
                if (fault != FAULT_STRAY_BYTE)
                    return;
            end
            if (i == n_elems)
                break;
            case ($urandom_range(0, 2))
                0:
                begin
                    c = 8'($urandom_range(0, 255));
                    while (c == CH_QUOTE || c == CH_BSLASH)
                        c = 8'($urandom_range(0, 255));
                    send_request(c, 1'b0);
                end
                1:
                begin
                    send_request(CH_BSLASH, 1'b0);
                    send_request(escape_letter($urandom_range(0, 7)), 1'b0);
                end
                default:
                begin
                    cls = $urandom_range(0, 4);
                    case (cls)
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2:       cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                        3:       cp = 16'($urandom_range(16'h0000, 16'hFFFF));
                        default:
                        begin
                            // encoding boundaries
                            case ($urandom_range(0, 4))
                                0:       cp = 16'h007F;
                                1:       cp = 16'h0080;
                                2:       cp = 16'h07FF;
                                3:       cp = 16'h0800;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                    endcase
                    send_unicode_escape(cp, 4'($urandom_range(0, 15)));
                end
            endcase
        end
        send_request(CH_QUOTE, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of the byte, each error, silent end while waiting, \u0000
    // and a three-byte code point with mixed-case digits.
    task automatic test_directed_cases();
        send_request(CH_UC_A, 1'b0);     // no opening quote
        send_request(8'hFF, 1'b1);       // end of text while waiting: no result
        send_request(CH_QUOTE, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_LC_N, 1'b0);
        send_unicode_escape(16'h0000, 4'b0000);
        send_unicode_escape(16'hFFFF, 4'b1010);
        send_request(CH_QUOTE, 1'b0);    // closes the string
        send_request(CH_QUOTE, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_LC_Q, 1'b0);     // unknown escape letter
        send_request(CH_QUOTE, 1'b0);
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_U, 1'b0);
        send_request(CH_LC_G, 1'b0);     // not a hex digit
        send_request(CH_QUOTE, 1'b0);
        send_request(8'h00, 1'b1);       // text ends inside the string
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while requests keep coming;
    // the request queue fills and the input must stall.
    task automatic test_output_backpressure();
        hold_off <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (4) send_random_string();
        send_request(CH_QUOTE, 1'b0);
        send_unicode_escape(16'h0800, 4'b1111);
        send_unicode_escape(16'hD83D, 4'b0101);
        send_unicode_escape(16'h07FF, 4'b0011);
        send_request(CH_QUOTE, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_strings();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            send_random_string();
        wait_drained();
    endtask

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_strings();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_results.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
